// File: hdl/fasmd_pkg.sv
// Shared types and constants of the single-precision add/sub/mul/div unit.
package fasmd_pkg;

   // Operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Binary32 bit patterns
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [30:0] EXP_ALL   = 31'h7F80_0000;

   // Queue depth between the front and the back
   localparam int QUEUE_DEPTH = 4;

   // Quotient bits produced by the divider, one per stage
   localparam int DIV_STEPS = 27;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic        last_pair;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        last_result;
   } rsp_type;

   // Classified word handed from the front to the back
   typedef struct packed {
      logic               special;
      logic [31:0]        special_value;
      logic [1:0]         operation;
      logic               sign;
      logic               eff_sub;
      logic signed [9:0]  exp_a;
      logic [23:0]        man_a;
      logic signed [9:0]  exp_b;
      logic [23:0]        man_b;
      logic               last;
   } work_type;

endpackage

// File: hdl/float32_add_sub_mul_div_unit.sv
// Single-precision add/sub/mul/div unit: front classifier, queue and back pipeline.
// Throughput: one word per cycle unless a valid result is held; the back pipeline moves as one.
// From the accepting edge to result valid, every operation passes queue write, core stage,
//   27 divider stages, normalize, shift and round.
// The 27-stage restoring divider, one quotient bit per stage, sets the latency.
// Reset clears all valid flags and queue pointers; payload registers are not reset.
module float32_add_sub_mul_div_unit #(
   parameter int QUEUE_DEPTH = fasmd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fasmd_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fasmd_pkg::rsp_type rsp_word
);

   logic                wrk_valid, wrk_full;
   fasmd_pkg::work_type wrk_word;
   logic                q_valid, q_take;
   fasmd_pkg::work_type q_word;

   fasmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .wrk_valid (wrk_valid),
      .wrk_word  (wrk_word),
      .wrk_full  (wrk_full)
   );

   fasmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (wrk_valid),
      .push_word  (wrk_word),
      .full       (wrk_full),
      .pop_en     (q_take),
      .pop_valid  (q_valid),
      .pop_word   (q_word)
   );

   fasmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_word   (q_word),
      .in_take   (q_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // A word held in the front keeps its content until the queue frees a slot
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      wrk_valid && wrk_full |=> wrk_valid && $stable(wrk_word))
      else $error("front word changed while queue full");

   // A pop from a full queue clears full, as no word is pushed while the queue is full
   a_queue_drain: assert property (@(posedge clock) disable iff (reset)
      wrk_full && q_valid && q_take |=> !wrk_full)
      else $error("queue still full after a pop");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// File: hdl/fasmd_front.sv
// Front end: accepts request words, resolves special operands and unpacks significands.
module fasmd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fasmd_pkg::req_type req_word,
   output logic               wrk_valid,
   output fasmd_pkg::work_type wrk_word,
   input  logic               wrk_full
);

   logic                 f_valid_ff;
   fasmd_pkg::work_type  f_word_ff;
   fasmd_pkg::work_type  f_word_in;

   logic [31:0] a, b;
   logic [30:0] mag_a, mag_b;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic        swap;
   logic [31:0] big, lit;
   logic signed [9:0] e_big, e_lit;
   logic [23:0] m_big, m_lit;
   logic [4:0]  lz_a, lz_b;

   // Count leading zeros of a 24-bit significand
   function automatic logic [4:0] lzc24(input logic [23:0] m);
      logic [4:0] n;
      logic       hit;
      n   = 5'd0;
      hit = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!hit && !m[i]) n = n + 5'd1;
         if (m[i]) hit = 1'b1;
      end
      return n;
   endfunction

   // Classify the operands
   always_comb begin
      a      = req_word.operand_a;
      b      = (req_word.operation == fasmd_pkg::OP_SUB) ?
               (req_word.operand_b ^ fasmd_pkg::SIGN_BIT) : req_word.operand_b;
      mag_a  = a[30:0];
      mag_b  = b[30:0];
      nan_a  = mag_a > fasmd_pkg::EXP_ALL;
      nan_b  = mag_b > fasmd_pkg::EXP_ALL;
      inf_a  = mag_a == fasmd_pkg::EXP_ALL;
      inf_b  = mag_b == fasmd_pkg::EXP_ALL;
      zero_a = mag_a == 31'd0;
      zero_b = mag_b == 31'd0;
      swap   = (req_word.operation == fasmd_pkg::OP_ADD ||
                req_word.operation == fasmd_pkg::OP_SUB) && (mag_a < mag_b);
      big    = swap ? b : a;
      lit    = swap ? a : b;
      e_big  = (big[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, big[30:23]});
      e_lit  = (lit[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, lit[30:23]});
      m_big  = {big[30:23] != 8'd0, big[22:0]};
      m_lit  = {lit[30:23] != 8'd0, lit[22:0]};
      lz_a   = lzc24(m_big);
      lz_b   = lzc24(m_lit);

      f_word_in               = '0;
      f_word_in.operation     = req_word.operation;
      f_word_in.last          = req_word.last_pair;
      f_word_in.exp_a         = e_big;
      f_word_in.man_a         = m_big;
      f_word_in.exp_b         = e_lit;
      f_word_in.man_b         = m_lit;
      f_word_in.sign          = a[31] ^ b[31];
      f_word_in.eff_sub       = a[31] ^ b[31];
      f_word_in.special_value = fasmd_pkg::QNAN_BITS;

      case (req_word.operation)
         fasmd_pkg::OP_ADD, fasmd_pkg::OP_SUB: begin
            f_word_in.sign = big[31];
            if (nan_a || nan_b) begin
               f_word_in.special = 1'b1;
            end else if (inf_a || inf_b) begin
               f_word_in.special = 1'b1;
               if (!(inf_a && inf_b && (a[31] != b[31])))
                  f_word_in.special_value = inf_a ? a : b;
            end else if (zero_a && zero_b) begin
               f_word_in.special       = 1'b1;
               f_word_in.special_value = (a[31] == b[31]) ? a : 32'd0;
            end else if (zero_a) begin
               f_word_in.special       = 1'b1;
               f_word_in.special_value = b;
            end else if (zero_b) begin
               f_word_in.special       = 1'b1;
               f_word_in.special_value = a;
            end
         end
         fasmd_pkg::OP_MUL: begin
            if (nan_a || nan_b) begin
               f_word_in.special = 1'b1;
            end else if (inf_a || inf_b) begin
               f_word_in.special = 1'b1;
               if (!(zero_a || zero_b))
                  f_word_in.special_value = {a[31] ^ b[31], fasmd_pkg::EXP_ALL};
            end else if (zero_a || zero_b) begin
               f_word_in.special       = 1'b1;
               f_word_in.special_value = {a[31] ^ b[31], 31'd0};
            end
         end
         default: begin
            // Normalize subnormal significands ahead of the divider
            f_word_in.man_a = m_big << lz_a;
            f_word_in.exp_a = e_big - $signed({5'd0, lz_a});
            f_word_in.man_b = m_lit << lz_b;
            f_word_in.exp_b = e_lit - $signed({5'd0, lz_b});
            if (nan_a || nan_b) begin
               f_word_in.special = 1'b1;
            end else if (inf_a) begin
               f_word_in.special = 1'b1;
               if (!inf_b)
                  f_word_in.special_value = {a[31] ^ b[31], fasmd_pkg::EXP_ALL};
            end else if (inf_b) begin
               f_word_in.special       = 1'b1;
               f_word_in.special_value = {a[31] ^ b[31], 31'd0};
            end else if (zero_b) begin
               f_word_in.special = 1'b1;
               if (!zero_a)
                  f_word_in.special_value = {a[31] ^ b[31], fasmd_pkg::EXP_ALL};
            end else if (zero_a) begin
               f_word_in.special       = 1'b1;
               f_word_in.special_value = {a[31] ^ b[31], 31'd0};
            end
         end
      endcase
   end

   // Hold the word while the queue is full
   assign req_stall = f_valid_ff && wrk_full;
   assign wrk_valid = f_valid_ff;
   assign wrk_word  = f_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (!f_valid_ff || !wrk_full) begin
         f_valid_ff <= req_valid;
      end
      if (!f_valid_ff || !wrk_full) begin
         f_word_ff <= f_word_in;
      end
   end

endmodule

// File: hdl/fasmd_queue.sv
// Short queue of classified words between the front and the back.
module fasmd_queue #(
   parameter int DEPTH = fasmd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  fasmd_pkg::work_type push_word,
   output logic                full,
   input  logic                pop_en,
   output logic                pop_valid,
   output fasmd_pkg::work_type pop_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fasmd_pkg::work_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_word  = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_en && pop_valid;

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_word;
   end

endmodule

// File: hdl/fasmd_back.sv
// Back end: aligned add, multiply, restoring divide, then normalize, round and pack.
module fasmd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fasmd_pkg::work_type in_word,
   output logic                in_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fasmd_pkg::rsp_type  rsp_word
);

   localparam int NS = fasmd_pkg::DIV_STEPS;

   typedef struct packed {
      logic               special;
      logic [31:0]        special_value;
      logic               is_div;
      logic               sign;
      logic signed [11:0] exp;
      logic [47:0]        man;
      logic [24:0]        rem;
      logic [23:0]        dvsr;
      logic               last;
   } stg_type;

   typedef struct packed {
      logic               special;
      logic [31:0]        special_value;
      logic               sign;
      logic               zero;
      logic signed [11:0] exp;
      logic signed [11:0] sh;
      logic [47:0]        man;
      logic               last;
   } nrm_type;

   typedef struct packed {
      logic               special;
      logic [31:0]        special_value;
      logic               sign;
      logic               zero;
      logic signed [11:0] lq;
      logic [23:0]        r;
      logic               g;
      logic               st;
      logic               last;
   } rnd_type;

   logic               en;
   logic               vld_ff [NS+1];
   stg_type            st_ff  [NS+1];
   stg_type            st_in  [NS+1];
   logic               n1_vld_ff, n2_vld_ff;
   nrm_type            n1_ff, n1_in;
   rnd_type            n2_ff, n2_in;
   logic               rsp_valid_ff;
   fasmd_pkg::rsp_type rsp_word_ff, rsp_word_in;

   // Core stage locals
   logic [9:0]  d;
   logic [4:0]  dsh;
   logic [53:0] al;
   logic [26:0] ma27, mbs;
   logic [27:0] sum28;
   // Normalize locals
   logic [47:0] m1;
   logic [5:0]  p;
   logic signed [11:0] sh0, minsh;
   // Shift locals
   logic [96:0] x;
   logic [5:0]  sc;
   logic [11:0] nsh;
   // Round locals
   logic [24:0] r25;
   logic [23:0] rn;
   logic signed [11:0] lq1, biased;

   // Position of the highest set bit
   function automatic logic [5:0] top_bit(input logic [47:0] m);
      logic [5:0] t;
      t = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (m[i]) t = 6'(i);
      end
      return t;
   endfunction

   assign en      = !rsp_valid_ff || !rsp_stall;
   assign in_take = en;

   // Core stage: align and add, multiply, or load the divider
   always_comb begin
      d     = in_word.exp_a - in_word.exp_b;
      dsh   = (d > 10'd31) ? 5'd31 : d[4:0];
      al    = {in_word.man_b, 30'd0} >> dsh;
      ma27  = {in_word.man_a, 3'b000};
      mbs   = al[53:27] | {26'd0, |al[26:0]};
      sum28 = in_word.eff_sub ? ({1'b0, ma27} - {1'b0, mbs}) : ({1'b0, ma27} + {1'b0, mbs});

      st_in[0]               = '0;
      st_in[0].special       = in_word.special;
      st_in[0].special_value = in_word.special_value;
      st_in[0].sign          = in_word.sign;
      st_in[0].last          = in_word.last;
      case (in_word.operation)
         fasmd_pkg::OP_MUL: begin
            st_in[0].man = in_word.man_a * in_word.man_b;
            st_in[0].exp = 12'(in_word.exp_a) + 12'(in_word.exp_b) - 12'sd300;
         end
         fasmd_pkg::OP_DIV: begin
            st_in[0].is_div = 1'b1;
            st_in[0].rem    = {1'b0, in_word.man_a};
            st_in[0].dvsr   = in_word.man_b;
            st_in[0].exp    = 12'(in_word.exp_a) - 12'(in_word.exp_b) - 12'sd26;
         end
         default: begin
            st_in[0].man = {20'd0, sum28};
            st_in[0].exp = 12'(in_word.exp_a) - 12'sd153;
         end
      endcase

      // One quotient bit per stage
      for (int k = 1; k <= NS; k++) begin
         logic        qb;
         logic [24:0] nr;
         st_in[k] = st_ff[k-1];
         qb = st_ff[k-1].rem >= {1'b0, st_ff[k-1].dvsr};
         nr = qb ? (st_ff[k-1].rem - {1'b0, st_ff[k-1].dvsr}) : st_ff[k-1].rem;
         if (st_ff[k-1].is_div) begin
            st_in[k].rem = {nr[23:0], 1'b0};
            st_in[k].man = {st_ff[k-1].man[46:0], qb};
         end
      end
   end

   // Find the leading one and the clamped shift
   always_comb begin
      m1    = st_ff[NS].man |
              {47'd0, st_ff[NS].is_div && (st_ff[NS].rem != 25'd0)};
      p     = top_bit(m1);
      sh0   = $signed({6'd0, p}) - 12'sd23;
      minsh = -12'sd149 - st_ff[NS].exp;
      n1_in.special       = st_ff[NS].special;
      n1_in.special_value = st_ff[NS].special_value;
      n1_in.sign          = st_ff[NS].sign;
      n1_in.zero          = m1 == 48'd0;
      n1_in.exp           = st_ff[NS].exp;
      n1_in.sh            = (sh0 < minsh) ? minsh : sh0;
      n1_in.man           = m1;
      n1_in.last          = st_ff[NS].last;
   end

   // Shift to 24 bits, keeping guard and sticky
   always_comb begin
      sc  = (n1_ff.sh > 12'sd50) ? 6'd50 : n1_ff.sh[5:0];
      nsh = -n1_ff.sh;
      x   = {n1_ff.man, 49'd0} >> sc;
      n2_in.special       = n1_ff.special;
      n2_in.special_value = n1_ff.special_value;
      n2_in.sign          = n1_ff.sign;
      n2_in.zero          = n1_ff.zero;
      n2_in.lq            = n1_ff.exp + n1_ff.sh;
      n2_in.last          = n1_ff.last;
      if (n1_ff.sh > 12'sd0) begin
         n2_in.r  = x[72:49];
         n2_in.g  = x[48];
         n2_in.st = |x[47:0];
      end else begin
         n2_in.r  = n1_ff.man[23:0] << nsh[4:0];
         n2_in.g  = 1'b0;
         n2_in.st = 1'b0;
      end
   end

   // Round to nearest even and pack
   always_comb begin
      r25    = {1'b0, n2_ff.r} + {24'd0, n2_ff.g && (n2_ff.st || n2_ff.r[0])};
      rn     = r25[24] ? r25[24:1] : r25[23:0];
      lq1    = r25[24] ? (n2_ff.lq + 12'sd1) : n2_ff.lq;
      biased = lq1 + 12'sd150;
      rsp_word_in.last_result = n2_ff.last;
      if (n2_ff.special)
         rsp_word_in.result_value = n2_ff.special_value;
      else if (n2_ff.zero)
         rsp_word_in.result_value = 32'd0;
      else if (!rn[23])
         rsp_word_in.result_value = {n2_ff.sign, 8'd0, rn[22:0]};
      else if (biased >= 12'sd255)
         rsp_word_in.result_value = {n2_ff.sign, fasmd_pkg::EXP_ALL};
      else
         rsp_word_in.result_value = {n2_ff.sign, biased[7:0], rn[22:0]};
   end

   // Advance the whole pipeline unless the result is held
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) vld_ff[k] <= 1'b0;
         n1_vld_ff    <= 1'b0;
         n2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= NS; k++) vld_ff[k] <= vld_ff[k-1];
         n1_vld_ff    <= vld_ff[NS];
         n2_vld_ff    <= n1_vld_ff;
         rsp_valid_ff <= n2_vld_ff;
      end
      if (en) begin
         for (int k = 0; k <= NS; k++) st_ff[k] <= st_in[k];
         n1_ff       <= n1_in;
         n2_ff       <= n2_in;
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
